FILE: hw/rtl/pfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared codes, letter constants, control types and helper functions of the
// Playfair encoder.
// ----------------------------------------------------------------------------
package pfe_pkg;

   // Operation codes carried on the input channel.
   localparam logic [2:0] OP_BEGIN_KEY = 3'd0;
   localparam logic [2:0] OP_KEY_CHAR  = 3'd1;
   localparam logic [2:0] OP_KEY_DONE  = 3'd2;
   localparam logic [2:0] OP_TEXT_CHAR = 3'd3;
   localparam logic [2:0] OP_LINE_END  = 3'd4;

   localparam int unsigned CELLS   = 25;
   localparam int unsigned LETTERS = 26;

   // Letter indexes, 'A' is zero.
   localparam logic [4:0] IDX_I    = 5'd8;
   localparam logic [4:0] IDX_J    = 5'd9;
   localparam logic [4:0] IDX_X    = 5'd23;
   localparam logic [4:0] IDX_Y    = 5'd24;
   localparam logic [4:0] IDX_LAST = 5'd25;
   localparam logic [4:0] FILL_FULL = 5'd25;
   localparam logic [2:0] LAST_COL  = 3'd4;

   localparam logic [6:0] ASCII_A = 7'h41;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic begin_key;
      logic key_place;
      logic fill_start;
      logic fill_step;
      logic hold_letter;
      logic text_pair;
      logic eol_pair;
      logic eol_empty;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic letter_ok;
      logic pend_valid;
      logic fill_last;
   } sts_type;

   // Returns {is_letter, index} with J folded into I.
   function automatic logic [5:0] letter_of(input logic [7:0] c);
      logic [7:0] idx;
      logic       ok;
      idx = 8'd0;
      ok  = 1'b0;
      if (c >= 8'h61 && c <= 8'h7A) begin
         idx = c - 8'h61;
         ok  = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         idx = c - 8'h41;
         ok  = 1'b1;
      end
      if (idx[4:0] == IDX_J) begin
         idx = {3'd0, IDX_I};
      end
      return {ok, idx[4:0]};
   endfunction

   // Step a row or column index by one, wrapping at five.
   function automatic logic [2:0] next5(input logic [2:0] v);
      return (v == LAST_COL) ? 3'd0 : v + 3'd1;
   endfunction

   // Linear cell address row * 5 + col.
   function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
      return {row, 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

endpackage

FILE: hw/rtl/pfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ctrl
// Controller of the Playfair encoder: decodes operations, sequences the key
// fill and the encryption steps, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module pfe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [2:0]       req_op,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output pfe_pkg::cmd_type cmd,
   input  pfe_pkg::sts_type sts
);
   import pfe_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FILL = 3'd1;
   localparam logic [2:0] S_POS  = 3'd2;
   localparam logic [2:0] S_CELL = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept;
   logic       out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_BEGIN_KEY: cmd.begin_key = 1'b1;
                  OP_KEY_CHAR:  cmd.key_place = 1'b1;
                  OP_KEY_DONE: begin
                     cmd.fill_start = 1'b1;
                     state_in       = S_FILL;
                  end
                  OP_TEXT_CHAR: begin
                     if (sts.letter_ok && !sts.pend_valid) begin
                        cmd.hold_letter = 1'b1;
                     end else if (sts.letter_ok) begin
                        cmd.text_pair = 1'b1;
                        state_in      = S_POS;
                     end
                  end
                  OP_LINE_END: begin
                     if (sts.pend_valid) begin
                        cmd.eol_pair = 1'b1;
                        state_in     = S_POS;
                     end else begin
                        cmd.eol_empty = 1'b1;
                        state_in      = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_POS:  state_in = S_CELL;
         S_CELL: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: hw/rtl/pfe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_dp
// Datapath of the Playfair encoder: letter square and position memories,
// key placement, pending letter and the output payload register.
// ----------------------------------------------------------------------------
module pfe_dp (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_char,
   input  pfe_pkg::cmd_type cmd,
   output pfe_pkg::sts_type sts,
   output logic [6:0]       first_letter,
   output logic [6:0]       second_letter,
   output logic             pair_valid,
   output logic             line_end
);
   import pfe_pkg::*;

   // Square holds letter indexes per cell; positions hold {row, col} per letter.
   logic [4:0] sq_mem  [CELLS];
   logic [5:0] pos_mem [LETTERS];

   logic [25:0] used_ff, used_in;
   logic [4:0]  fill_ff, fill_in;
   logic [2:0]  frow_ff, frow_in;
   logic [2:0]  fcol_ff, fcol_in;
   logic [4:0]  k_ff, k_in;
   logic        pend_ff, pend_in;
   logic [4:0]  pletter_ff, pletter_in;

   logic [4:0]  a_ff, b_ff;
   logic        pair_ff, eol_ff;
   logic [5:0]  pos_a_ff, pos_b_ff;
   logic [4:0]  sq_a_ff, sq_b_ff;
   logic [6:0]  first_ff, second_ff;
   logic        pv_ff, le_ff;

   logic [5:0]  lt;
   logic [4:0]  place_idx;
   logic        place_req, place_ok;
   logic [2:0]  r1, c1, r2, c2;
   logic [4:0]  addr1, addr2;
   logic        is_xx;
   logic [4:0]  e1, e2;

   assign lt            = letter_of(req_char);
   assign sts.letter_ok = lt[5];
   assign sts.pend_valid = pend_ff;
   assign sts.fill_last = (k_ff == IDX_LAST);

   assign place_req = (cmd.key_place && lt[5]) || cmd.fill_step;
   assign place_idx = cmd.fill_step ? k_ff : lt[4:0];
   assign place_ok  = place_req && (fill_ff < FILL_FULL) && !used_ff[place_idx];

   always_comb begin
      used_in    = used_ff;
      fill_in    = fill_ff;
      frow_in    = frow_ff;
      fcol_in    = fcol_ff;
      k_in       = k_ff;
      pend_in    = pend_ff;
      pletter_in = pletter_ff;
      if (cmd.begin_key) begin
         used_in    = 26'd1 << IDX_J;
         fill_in    = 5'd0;
         frow_in    = 3'd0;
         fcol_in    = 3'd0;
         pend_in    = 1'b0;
         pletter_in = 5'd0;
      end
      if (place_ok) begin
         used_in[place_idx] = 1'b1;
         fill_in = fill_ff + 5'd1;
         fcol_in = next5(fcol_ff);
         if (fcol_ff == LAST_COL) begin
            frow_in = frow_ff + 3'd1;
         end
      end
      if (cmd.fill_start) begin
         k_in = 5'd0;
      end else if (cmd.fill_step) begin
         k_in = k_ff + 5'd1;
      end
      if (cmd.hold_letter) begin
         pend_in    = 1'b1;
         pletter_in = lt[4:0];
      end
      if ((cmd.text_pair && lt[4:0] != pletter_ff) || cmd.eol_pair) begin
         pend_in    = 1'b0;
         pletter_in = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= 26'd1 << IDX_J;
         fill_ff    <= 5'd0;
         frow_ff    <= 3'd0;
         fcol_ff    <= 3'd0;
         k_ff       <= 5'd0;
         pend_ff    <= 1'b0;
         pletter_ff <= 5'd0;
      end else begin
         used_ff    <= used_in;
         fill_ff    <= fill_in;
         frow_ff    <= frow_in;
         fcol_ff    <= fcol_in;
         k_ff       <= k_in;
         pend_ff    <= pend_in;
         pletter_ff <= pletter_in;
      end
   end

   // Memory writes for a placed letter.
   always_ff @(posedge clock) begin
      if (place_ok) begin
         sq_mem[fill_ff]    <= place_idx;
         pos_mem[place_idx] <= {frow_ff, fcol_ff};
      end
   end

   // Pair capture at the accepting transfer.
   always_ff @(posedge clock) begin
      if (cmd.text_pair) begin
         a_ff    <= pletter_ff;
         b_ff    <= (lt[4:0] == pletter_ff) ? IDX_X : lt[4:0];
         pair_ff <= 1'b1;
         eol_ff  <= 1'b0;
      end else if (cmd.eol_pair) begin
         a_ff    <= pletter_ff;
         b_ff    <= IDX_X;
         pair_ff <= 1'b1;
         eol_ff  <= 1'b1;
      end else if (cmd.eol_empty) begin
         pair_ff <= 1'b0;
         eol_ff  <= 1'b1;
      end
   end

   // Position lookup, then square lookup; both read ports registered.
   always_ff @(posedge clock) begin
      pos_a_ff <= pos_mem[a_ff];
      pos_b_ff <= pos_mem[b_ff];
   end

   assign r1 = pos_a_ff[5:3];
   assign c1 = pos_a_ff[2:0];
   assign r2 = pos_b_ff[5:3];
   assign c2 = pos_b_ff[2:0];

   always_comb begin
      priority if (r1 == r2) begin
         addr1 = cell_addr(r1, next5(c1));
         addr2 = cell_addr(r2, next5(c2));
      end else if (c1 == c2) begin
         addr1 = cell_addr(next5(r1), c1);
         addr2 = cell_addr(next5(r2), c2);
      end else begin
         addr1 = cell_addr(r1, c2);
         addr2 = cell_addr(r2, c1);
      end
   end

   always_ff @(posedge clock) begin
      sq_a_ff <= sq_mem[addr1];
      sq_b_ff <= sq_mem[addr2];
   end

   assign is_xx = (a_ff == IDX_X) && (b_ff == IDX_X);
   assign e1    = is_xx ? IDX_Y : sq_a_ff;
   assign e2    = is_xx ? IDX_Y : sq_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         first_ff  <= pair_ff ? ASCII_A + {2'b00, e1} : 7'd0;
         second_ff <= pair_ff ? ASCII_A + {2'b00, e2} : 7'd0;
         pv_ff     <= pair_ff;
         le_ff     <= eol_ff;
      end
   end

   assign first_letter  = first_ff;
   assign second_letter = second_ff;
   assign pair_valid    = pv_ff;
   assign line_end      = le_ff;

endmodule

FILE: hw/rtl/playfair_cipher_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_cipher_encoder
// Playfair encryption of a filtered letter stream with an on-chip key square.
// ----------------------------------------------------------------------------
// Usage: each transfer on the req channel carries an operation in req_tuser
// and a raw ASCII byte in req_tdata. Begin-key, key-character and text
// characters that do not complete a pair produce no result. Key-complete
// walks the alphabet once, one letter per cycle, and req_tready stays low
// until the walk is done. A text character that completes a pair, or an
// end-of-line, produces exactly one rsp transfer: the cipher letters in
// rsp_tdata, pair_valid in rsp_tuser and line_end in rsp_tlast. A pair goes
// from its transfer through a position memory read, a square memory read
// and an output register load to rsp_tvalid, and the controller takes the
// next item only after that load, so one pair is done before the next is
// taken; the two sequential memory lookups set the pace. The result sits
// in an output register, so the next item is taken while it waits; if the
// receiver stalls, the following result waits in the controller and
// req_tready stays low until the output register frees. Reset clears the
// used-letter set (J only), the fill count and the pending letter; the
// square memories keep their contents until written, so a key must be
// built before any text is sent.
// ----------------------------------------------------------------------------
module playfair_cipher_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] first_letter, [13:7] second_letter
   output logic        rsp_tuser,   // [0] pair_valid
   output logic        rsp_tlast    // line_end
);
   import pfe_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [6:0] first_letter;
   logic [6:0] second_letter;

   // The controller decodes each op and runs the multi-cycle sequences.
   pfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the square, the pending letter and the result payload.
   pfe_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_char      (req_tdata),
      .cmd           (cmd),
      .sts           (sts),
      .first_letter  (first_letter),
      .second_letter (second_letter),
      .pair_valid    (rsp_tuser),
      .line_end      (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, second_letter, first_letter};

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Playfair encoder. A short scripted sequence
// covers the corner cases, then random key sessions with text lines follow.
// Every result transfer is compared with the output of a behavioral cipher
// model with its own copy of the key square, or for fixed script rows with
// a result typed in by hand. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
   import pfe_pkg::*;

   // One result transfer, in the order of the fields in rsp_tdata and beyond.
   typedef struct packed {
      logic [6:0] first_letter;
      logic [6:0] second_letter;
      logic       pair_valid;
      logic       line_end;
   } digraph_type;

   // One row of the scripted sequence. When fixed is set, want holds the
   // result typed in by hand; otherwise the cipher model decides.
   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  ch;
      logic        fixed;
      digraph_type want;
   } script_row_type;

   // Operation codes that the block must ignore.
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   localparam int unsigned RANDOM_OPS   = 850;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned MAX_REPORTS  = 10;

   localparam digraph_type NONE        = {7'h00, 7'h00, 1'b0, 1'b0};
   localparam digraph_type NO_PAIR_EOL = {7'h00, 7'h00, 1'b0, 1'b1};
   localparam digraph_type YY_PAIR     = {7'h59, 7'h59, 1'b1, 1'b0};
   localparam digraph_type YY_PAIR_EOL = {7'h59, 7'h59, 1'b1, 1'b1};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] char_in
   logic [2:0]  req_tuser;   // [2:0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [6:0] first_letter, [13:7] second_letter
   logic        rsp_tuser;   // [0] pair_valid
   logic        rsp_tlast;   // line_end

   // Cipher model state: the square, where each letter sits, which letters
   // are placed, how many cells are filled, and the letter awaiting a partner.
   logic [4:0]  sq_letter [CELLS];
   logic [4:0]  sq_pos    [LETTERS];
   logic [25:0] used_set;
   logic [4:0]  filled;
   logic [4:0]  held_letter;
   logic        held_valid;

   digraph_type digraph_q [$];     // results still owed by the block
   int unsigned miss_count  = 0;
   int unsigned ops_issued  = 0;   // input transfers so far
   int unsigned cycle_count = 0;
   logic        steady_send;       // when set, the sender never idles

   playfair_cipher_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Returns {is_letter, index}. Clearing bit 5 raises lower case; the only
   // bytes that land in 'A'..'Z' that way are the two letter ranges.
   function automatic logic [5:0] fold_letter(input logic [7:0] c);
      logic [7:0] up;
      logic       ok;
      up = c & 8'hDF;
      ok = (up >= 8'h41) && (up <= 8'h5A);
      up = up - 8'h41;
      if (up[4:0] == IDX_J) begin
         up[4:0] = IDX_I;
      end
      return {ok, up[4:0]};
   endfunction

   // Appends a letter to the square unless it is already there or the
   // square is full.
   task automatic place_letter(input logic [4:0] idx);
      if (filled < FILL_FULL && !used_set[idx]) begin
         used_set[idx]     = 1'b1;
         sq_letter[filled] = idx;
         sq_pos[idx]       = filled;
         filled            = filled + 5'd1;
      end
   endtask

   function automatic logic [4:0] cell_at(input int r, input int c);
      return sq_letter[(r % 5) * 5 + (c % 5)];
   endfunction

   // Encrypts one digraph with the current square.
   function automatic digraph_type encipher(input logic [4:0] a, input logic [4:0] b);
      int          r1, c1, r2, c2;
      logic [4:0]  e1, e2;
      digraph_type d;
      if (a == IDX_X && b == IDX_X) begin
         // A doubled X cannot be split again, so it has its own fixed answer.
         e1 = IDX_Y;
         e2 = IDX_Y;
      end else begin
         r1 = sq_pos[a] / 5;
         c1 = sq_pos[a] % 5;
         r2 = sq_pos[b] / 5;
         c2 = sq_pos[b] % 5;
         if (r1 == r2) begin
            e1 = cell_at(r1, c1 + 1);
            e2 = cell_at(r2, c2 + 1);
         end else if (c1 == c2) begin
            e1 = cell_at(r1 + 1, c1);
            e2 = cell_at(r2 + 1, c2);
         end else begin
            e1 = cell_at(r1, c2);
            e2 = cell_at(r2, c1);
         end
      end
      d.first_letter  = ASCII_A + {2'b00, e1};
      d.second_letter = ASCII_A + {2'b00, e2};
      d.pair_valid    = 1'b1;
      d.line_end      = 1'b0;
      return d;
   endfunction

   // Advances the cipher model by one accepted operation. emits tells
   // whether the block owes a result transfer for it.
   task automatic encipher_step(input logic [2:0] op, input logic [7:0] ch,
                                output logic emits, output digraph_type res);
      logic [5:0] lt;
      logic [4:0] k;
      emits = 1'b0;
      res   = NONE;
      lt    = fold_letter(ch);
      case (op)
         OP_BEGIN_KEY: begin
            // Old square entries stay; only the bookkeeping starts over.
            used_set    = 26'd1 << IDX_J;
            filled      = 5'd0;
            held_letter = 5'd0;
            held_valid  = 1'b0;
         end
         OP_KEY_CHAR: begin
            if (lt[5]) begin
               place_letter(lt[4:0]);
            end
         end
         OP_KEY_DONE: begin
            k = 5'd0;
            repeat (LETTERS) begin
               place_letter(k);
               k = k + 5'd1;
            end
         end
         OP_TEXT_CHAR: begin
            if (lt[5]) begin
               if (!held_valid) begin
                  held_letter = lt[4:0];
                  held_valid  = 1'b1;
               end else if (lt[4:0] == held_letter) begin
                  // A doubled letter is split by X and starts the next pair.
                  res   = encipher(held_letter, IDX_X);
                  emits = 1'b1;
               end else begin
                  res         = encipher(held_letter, lt[4:0]);
                  emits       = 1'b1;
                  held_valid  = 1'b0;
                  held_letter = 5'd0;
               end
            end
         end
         OP_LINE_END: begin
            if (held_valid) begin
               res         = encipher(held_letter, IDX_X);
               held_valid  = 1'b0;
               held_letter = 5'd0;
            end
            res.line_end = 1'b1;
            emits        = 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   function automatic logic [7:0] any_letter();
      logic [7:0] base;
      base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
      return base + 8'($urandom_range(0, 25));
   endfunction

   // Text bytes lean toward repeats and X so that doubled letters and the
   // XX digraph show up often.
   function automatic logic [7:0] text_byte(input logic [7:0] prev);
      int unsigned r;
      logic [7:0]  b;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         b = 8'($urandom_range(0, 255));
      end else if (r < 22) begin
         b = prev;
      end else if (r < 32) begin
         b = $urandom_range(0, 1) ? 8'h78 : 8'h58;
      end else begin
         b = any_letter();
      end
      return b;
   endfunction

   function automatic script_row_type row(input logic [2:0] op, input logic [7:0] ch,
                                          input logic fixed, input digraph_type want);
      return {op, ch, fixed, want};
   endfunction

   // Offers one operation, waits for its transfer and records what the
   // block owes for it.
   task automatic issue_op(input logic [2:0] op, input logic [7:0] ch,
                           input logic fixed, input digraph_type want);
      int unsigned gap;
      logic        emits;
      digraph_type res;
      gap = steady_send ? 0 : idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      encipher_step(op, ch, emits, res);
      if (emits) begin
         digraph_q.push_back(fixed ? want : res);
      end
      ops_issued++;
   endtask

   // One key session: a fresh key, sometimes text before the key is
   // finished, then a few lines of text.
   task automatic random_session();
      int unsigned nkey, nlines, nchars;
      logic [7:0]  ch, last_ch;
      logic [2:0]  junk_op;
      steady_send = ($urandom_range(0, 4) == 0);
      issue_op(OP_BEGIN_KEY, 8'($urandom_range(0, 255)), 1'b0, NONE);
      nkey = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 10);
      repeat (nkey) begin
         ch = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : any_letter();
         issue_op(OP_KEY_CHAR, ch, 1'b0, NONE);
      end
      // The square from the previous session fills in the cells not yet
      // rewritten, so text here is well defined.
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 6)) issue_op(OP_TEXT_CHAR, any_letter(), 1'b0, NONE);
      end
      issue_op(OP_KEY_DONE, 8'($urandom_range(0, 255)), 1'b0, NONE);
      if ($urandom_range(0, 3) == 0) begin
         issue_op(OP_KEY_CHAR, any_letter(), 1'b0, NONE);
      end
      nlines = $urandom_range(2, 6);
      repeat (nlines) begin
         nchars  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
         last_ch = any_letter();
         repeat (nchars) begin
            ch = text_byte(last_ch);
            if ($urandom_range(0, 39) == 0) begin
               junk_op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
               issue_op(junk_op, ch, 1'b0, NONE);
            end else begin
               issue_op(OP_TEXT_CHAR, ch, 1'b0, NONE);
            end
            last_ch = ch;
         end
         issue_op(OP_LINE_END, 8'($urandom_range(0, 255)), 1'b0, NONE);
      end
   endtask

   task automatic log_miss(input string why, input digraph_type want,
                           input digraph_type got);
      miss_count++;
      if (miss_count <= MAX_REPORTS) begin
         $display("%0t %s: expected first %h second %h pair %b end %b,",
                  $realtime, why, want.first_letter, want.second_letter,
                  want.pair_valid, want.line_end);
         $display("   got first %h second %h pair %b end %b",
                  got.first_letter, got.second_letter, got.pair_valid,
                  got.line_end);
      end
   endtask

   // Result side: ready for a random stretch, then a random stall. A long
   // stretch now and then gives runs at full rate.
   initial begin
      int unsigned run, stall;
      forever begin
         rsp_tready <= 1'b1;
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         stall = idle_len();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Each result transfer is checked against the oldest owed result.
   always @(posedge clock) begin : check_results
      digraph_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[6:0], rsp_tdata[13:7], rsp_tuser, rsp_tlast};
         if (digraph_q.size() == 0) begin
            log_miss("result with nothing outstanding", NONE, got);
         end else begin
            want = digraph_q.pop_front();
            if (got !== want) begin
               log_miss("result mismatch", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      script_row_type script [$];
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= OP_BEGIN_KEY;
      reset      <= 1'b1;
      steady_send = 1'b0;
      used_set    = 26'd1 << IDX_J;
      filled      = 5'd0;
      held_letter = 5'd0;
      held_valid  = 1'b0;
      foreach (sq_letter[i]) sq_letter[i] = 5'd0;
      foreach (sq_pos[i]) sq_pos[i] = 5'd0;

      // End of line with nothing pending, and an unused code, right after reset.
      script.push_back(row(OP_LINE_END,  8'h00, 1'b1, NO_PAIR_EOL));
      script.push_back(row(OP_UNUSED_HI, 8'hFF, 1'b0, NONE));
      // Key "PAJP" plus a non-letter: J folds to I, the second P is dropped.
      script.push_back(row(OP_BEGIN_KEY, 8'h00, 1'b0, NONE));
      script.push_back(row(OP_KEY_CHAR,  "p",   1'b0, NONE));
      script.push_back(row(OP_KEY_CHAR,  "a",   1'b0, NONE));
      script.push_back(row(OP_KEY_CHAR,  "J",   1'b0, NONE));
      script.push_back(row(OP_KEY_CHAR,  "P",   1'b0, NONE));
      script.push_back(row(OP_KEY_CHAR,  8'hFF, 1'b0, NONE));
      script.push_back(row(OP_KEY_DONE,  8'h00, 1'b0, NONE));
      // The square is full now, so this key letter has no effect.
      script.push_back(row(OP_KEY_CHAR,  "q",   1'b0, NONE));
      // A doubled X gives YY and leaves X pending; the line end closes it.
      script.push_back(row(OP_TEXT_CHAR, "x",   1'b0, NONE));
      script.push_back(row(OP_TEXT_CHAR, "X",   1'b1, YY_PAIR));
      script.push_back(row(OP_LINE_END,  8'h00, 1'b1, YY_PAIR_EOL));
      // Doubled E is split by X, then E with I (from j) forms a rectangle.
      script.push_back(row(OP_TEXT_CHAR, "e",   1'b0, NONE));
      script.push_back(row(OP_TEXT_CHAR, "e",   1'b0, NONE));
      script.push_back(row(OP_TEXT_CHAR, "j",   1'b0, NONE));
      // P and V share the first column, with wrap from the bottom row.
      script.push_back(row(OP_TEXT_CHAR, "p",   1'b0, NONE));
      script.push_back(row(OP_TEXT_CHAR, "v",   1'b0, NONE));
      // A lone Z at line end pairs with X in the same row and wraps right.
      script.push_back(row(OP_TEXT_CHAR, "z",   1'b0, NONE));
      script.push_back(row(OP_LINE_END,  8'h00, 1'b0, NONE));
      // Begin-key drops the pending letter.
      script.push_back(row(OP_TEXT_CHAR, "m",   1'b0, NONE));
      script.push_back(row(OP_BEGIN_KEY, 8'h5A, 1'b0, NONE));
      script.push_back(row(OP_LINE_END,  8'h00, 1'b1, NO_PAIR_EOL));
      // Text before key-complete uses the square as it stands.
      script.push_back(row(OP_TEXT_CHAR, "k",   1'b0, NONE));
      script.push_back(row(OP_TEXT_CHAR, "y",   1'b0, NONE));
      script.push_back(row(OP_KEY_DONE,  8'h00, 1'b0, NONE));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         issue_op(script[i].op, script[i].ch, script[i].fixed, script[i].want);
      end
      while (ops_issued < RANDOM_OPS) begin
         random_session();
      end
      req_tvalid <= 1'b0;

      // Let every owed result arrive, then give stray transfers time to show.
      while (digraph_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (miss_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
